FILE: rtl/rpm_pkg.sv
// Shared types, constants and tables for the rigid 2D point match block.
`timescale 1ns / 1ps
`default_nettype none

package rpm_pkg;

  // Item and accumulator widths
  localparam int COORD_BITS = 20;
  localparam int MAX_PAIRS  = 1024;
  localparam int CNT_W      = $clog2(MAX_PAIRS + 1);
  localparam int SUM_W      = 30;
  localparam int XSUM_W     = 52;
  localparam int ACC_W      = 64;

  // Shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SPLIT  = 26;

  // CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = 34;
  localparam int ATAN_IDX_W   = 5;

  // Rounding divider
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int DVSR_W    = 32;
  localparam int QUO_W     = DIV_W + 1;

  // Result widths
  localparam int ANG_W   = 16;
  localparam int TRIG_W  = 16;
  localparam int SHIFT_W = 24;

  localparam int ANG_SHIFT = 16;
  localparam int FRAC_Q15  = 15;

  localparam logic signed [CW-1:0] PI_Q29      = CW'(64'sd1686629713);
  localparam logic signed [CW-1:0] HALF_PI_Q29 = CW'(64'sd843314857);
  localparam logic signed [CW-1:0] UNIT_Q30    = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] ANG_ROUND   = CW'(64'sd32768);

  localparam logic [ACC_W-1:0] NORM_HI = ACC_W'(64'd1) << 29;
  localparam logic [ACC_W-1:0] NORM_LO = ACC_W'(64'd1) << 28;

  localparam logic signed [QUO_W-1:0] TRIG_HI  = QUO_W'(32767);
  localparam logic signed [QUO_W-1:0] TRIG_LO  = QUO_W'(-32768);
  localparam logic signed [QUO_W-1:0] SHIFT_HI = QUO_W'(8388607);
  localparam logic signed [QUO_W-1:0] SHIFT_LO = QUO_W'(-8388608);
  localparam logic signed [TRIG_W-1:0] COS_ONE = TRIG_W'(32767);

  // Operations of the shared multiplier; the tag selects where a product lands
  typedef enum logic [3:0] {
    OP_RX_MX,
    OP_RY_MY,
    OP_RY_MX,
    OP_RX_MY,
    OP_NCR_LO,
    OP_NCR_HI,
    OP_SRY_SMX,
    OP_SRX_SMY,
    OP_NDT_LO,
    OP_NDT_HI,
    OP_SRX_SMX,
    OP_SRY_SMY,
    OP_C_SMX,
    OP_S_SMY,
    OP_S_SMX,
    OP_C_SMY
  } op_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_req_t;

  // atan(2^-i) in Q.29, rounded
  function automatic logic signed [CW-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] i);
    logic signed [CW-1:0] v;
    unique case (i)
      5'd0:    v = CW'(64'sd421657428);
      5'd1:    v = CW'(64'sd248918915);
      5'd2:    v = CW'(64'sd131521918);
      5'd3:    v = CW'(64'sd66762579);
      5'd4:    v = CW'(64'sd33510843);
      5'd5:    v = CW'(64'sd16771758);
      5'd6:    v = CW'(64'sd8387925);
      5'd7:    v = CW'(64'sd4194219);
      5'd8:    v = CW'(64'sd2097141);
      5'd9:    v = CW'(64'sd1048575);
      5'd10:   v = CW'(64'sd524288);
      5'd11:   v = CW'(64'sd262144);
      5'd12:   v = CW'(64'sd131072);
      5'd13:   v = CW'(64'sd65536);
      5'd14:   v = CW'(64'sd32768);
      5'd15:   v = CW'(64'sd16384);
      5'd16:   v = CW'(64'sd8192);
      5'd17:   v = CW'(64'sd4096);
      5'd18:   v = CW'(64'sd2048);
      5'd19:   v = CW'(64'sd1024);
      5'd20:   v = CW'(64'sd512);
      5'd21:   v = CW'(64'sd256);
      5'd22:   v = CW'(64'sd128);
      5'd23:   v = CW'(64'sd64);
      5'd24:   v = CW'(64'sd32);
      5'd25:   v = CW'(64'sd16);
      5'd26:   v = CW'(64'sd8);
      5'd27:   v = CW'(64'sd4);
      5'd28:   v = CW'(64'sd2);
      5'd29:   v = CW'(64'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // CORDIC gain in Q.30: isqrt(prod(1 + 2^-2i) << 30), evaluated at elaboration
  function automatic logic [63:0] cordic_gain_q30();
    logic [63:0] k2;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    k2 = 64'd1 << 30;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      k2 = k2 + (k2 >> (2 * i));
    end
    v = k2 << 30;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  localparam logic [DVSR_W-1:0] KQ = DVSR_W'(cordic_gain_q30());

endpackage

`default_nettype wire

FILE: rtl/rpm_mul.sv
// Shared signed 32x32 multiplier with registered product and operation tag.
`timescale 1ns / 1ps
`default_nettype none

module rpm_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  rpm_pkg::op_t                         op,
  input  logic signed [rpm_pkg::MUL_W-1:0]     a,
  input  logic signed [rpm_pkg::MUL_W-1:0]     b,
  output logic                                 vld,
  output rpm_pkg::op_t                         tag,
  output logic signed [rpm_pkg::PROD_W-1:0]    prod
);
  import rpm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= en;
    end
    if (en) begin
      prod <= a * b;
      tag  <= op;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rpm_div.sv
// Iterative restoring divider, one quotient bit per cycle, rounds half away from zero.
`timescale 1ns / 1ps
`default_nettype none

module rpm_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [rpm_pkg::ACC_W-1:0]     dividend,
  input  logic [rpm_pkg::DVSR_W-1:0]           divisor,
  output logic                                 done,
  output logic signed [rpm_pkg::QUO_W-1:0]     quotient
);
  import rpm_pkg::*;

  logic                 run;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVSR_W-1:0]    dvsr;
  logic [DVSR_W-1:0]    rem;
  logic [DIV_W-1:0]     dq;
  logic [ACC_W-1:0]     mag;
  logic [DVSR_W:0]      rem_sh;
  logic                 fits;

  // |n| + d/2 is the rounded dividend
  always_comb begin
    mag    = ACC_W'(dividend[ACC_W-1] ? -dividend : dividend) + ACC_W'(divisor >> 1);
    rem_sh = {rem, dq[DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvsr};
  end

  assign quotient = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == DIV_CNT_W'(DIV_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      neg  <= dividend[ACC_W-1];
      dq   <= mag[DIV_W-1:0];
      rem  <= '0;
      dvsr <= divisor;
      cnt  <= '0;
    end else if (run) begin
      if (fits) begin
        rem <= DVSR_W'(rem_sh - {1'b0, dvsr});
        dq  <= {dq[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVSR_W-1:0];
        dq  <= {dq[DIV_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rpm_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
`timescale 1ns / 1ps
`default_nettype none

module rpm_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  rpm_pkg::cordic_req_t              req,
  input  logic signed [rpm_pkg::CW-1:0]     x0,
  input  logic signed [rpm_pkg::CW-1:0]     y0,
  input  logic signed [rpm_pkg::CW-1:0]     z0,
  output logic                              done,
  output logic signed [rpm_pkg::CW-1:0]     x,
  output logic signed [rpm_pkg::CW-1:0]     y,
  output logic signed [rpm_pkg::CW-1:0]     z
);
  import rpm_pkg::*;

  logic              run;
  logic              rotate;
  logic [STEP_W-1:0] step;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] da;
  logic              ccw;

  // Vectoring drives y toward zero, rotation drives z toward zero
  always_comb begin
    xs  = x >>> step;
    ys  = y >>> step;
    da  = atan_q29(ATAN_IDX_W'(step));
    ccw = rotate ? !z[CW-1] : y[CW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run && step == STEP_W'(CORDIC_STEPS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
    if (req.start) begin
      x      <= x0;
      y      <= y0;
      z      <= z0;
      step   <= '0;
      rotate <= req.rotate;
    end else if (run) begin
      if (ccw) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - da;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + da;
      end
      step <= step + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rigid_2d_point_match_core.sv
// Top level: rigid 2D point-set registration (sums, angle, cos/sin, translation).
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_ready  ref_x ref_y mov_x mov_y (s20 Q15.4), last_point
// out      out_valid/out_ready  angle_theta (Q3.13), cos_theta sin_theta (Q1.15),
//                               shift_x shift_y (Q19.4)
//
// A point pair is handled in order: accept, four products through the one shared
// 32x32 multiplier, then a drain step that folds the last product into the sums.
// An item marked last adds the set solve: 12 products, the normalize shifts,
// two 16-step CORDIC passes and four divides, all sequenced on the shared
// multiplier, CORDIC and divider.
// Synchronous reset clears the sums, the pair count, the sequencer and out_valid.
// in_ready is high only in idle; a waiting result does not block new items,
// a finished solve holds in its last step until the output register is free.

module rigid_2d_point_match_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [rpm_pkg::COORD_BITS-1:0]   ref_x,
  input  logic signed [rpm_pkg::COORD_BITS-1:0]   ref_y,
  input  logic signed [rpm_pkg::COORD_BITS-1:0]   mov_x,
  input  logic signed [rpm_pkg::COORD_BITS-1:0]   mov_y,
  input  logic                                    last_point,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rpm_pkg::ANG_W-1:0]        angle_theta,
  output logic signed [rpm_pkg::TRIG_W-1:0]       cos_theta,
  output logic signed [rpm_pkg::TRIG_W-1:0]       sin_theta,
  output logic signed [rpm_pkg::SHIFT_W-1:0]      shift_x,
  output logic signed [rpm_pkg::SHIFT_W-1:0]      shift_y
);
  import rpm_pkg::*;

  typedef enum logic [4:0] {
    IDLE, PT_MUL, PT_DRAIN, FIN_MUL, FIN_DRAIN, PREP, MAG, NORM,
    VEC_GO, VEC_WAIT, ROT_GO, ROT_WAIT, COS_GO, COS_WAIT, SIN_GO, SIN_WAIT,
    SH_MUL, SH_DRAIN, SHX_GO, SHX_WAIT, SHY_GO, SHY_WAIT, EMIT
  } state_t;

  state_t state;

  // Current pair
  logic signed [COORD_BITS-1:0] rx, ry, mx, my;
  logic                         last_r;

  // Set sums
  logic signed [SUM_W-1:0]  sum_ref_x, sum_ref_y, sum_mov_x, sum_mov_y;
  logic signed [XSUM_W-1:0] sum_dot, sum_cross;
  logic [CNT_W-1:0]         pair_count;

  // num/den hold N-scaled numerator and denominator, later the shift dividends
  logic signed [ACC_W-1:0] num, den;
  logic signed [ACC_W-1:0] vx, vy;
  logic [ACC_W-1:0]        m;
  logic signed [CW-1:0]    zinit;
  logic                    rot_neg;
  logic signed [CW-1:0]    cx, cy;
  logic signed [ANG_W-1:0]  angle_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic signed [SHIFT_W-1:0] shx_r, shy_r;

  op_t op_cur;

  // Shared multiplier
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic                     mul_vld;
  op_t                      mul_tag;
  logic signed [PROD_W-1:0] prod;

  // CORDIC
  cordic_req_t          cord_req;
  logic signed [CW-1:0] cord_x0, cord_y0, cord_z0;
  logic                 cord_done;
  logic signed [CW-1:0] cord_x, cord_y, cord_z;

  // Divider
  logic                     div_start;
  logic signed [ACC_W-1:0]  div_n;
  logic [DVSR_W-1:0]        div_d;
  logic                     div_done;
  logic signed [QUO_W-1:0]  quo;

  // Derived values
  logic [ACC_W-1:0]         ax, ay;
  logic signed [CW-1:0]     zc, az;
  logic signed [ANG_W-1:0]  aq, ang_next;
  logic signed [CW-1:0]     th, th_fold;
  logic                     fold_neg;
  logic signed [TRIG_W-1:0] trig_sat;
  logic signed [SHIFT_W-1:0] shift_sat;
  logic                     take_in;
  logic                     emit_go;

  assign in_ready = (state == IDLE);
  assign take_in  = in_valid && in_ready;
  assign emit_go  = (state == EMIT) && (!out_valid || out_ready);

  // Operand select for the shared multiplier
  always_comb begin
    mul_en = (state == PT_MUL) || (state == FIN_MUL) || (state == SH_MUL);
    unique case (op_cur)
      OP_RX_MX:   begin mul_a = MUL_W'(rx); mul_b = MUL_W'(mx); end
      OP_RY_MY:   begin mul_a = MUL_W'(ry); mul_b = MUL_W'(my); end
      OP_RY_MX:   begin mul_a = MUL_W'(ry); mul_b = MUL_W'(mx); end
      OP_RX_MY:   begin mul_a = MUL_W'(rx); mul_b = MUL_W'(my); end
      OP_NCR_LO:  begin
        mul_a = $signed(MUL_W'(pair_count));
        mul_b = $signed(MUL_W'(sum_cross[SPLIT-1:0]));
      end
      OP_NCR_HI:  begin
        mul_a = $signed(MUL_W'(pair_count));
        mul_b = MUL_W'(sum_cross >>> SPLIT);
      end
      OP_SRY_SMX: begin mul_a = MUL_W'(sum_ref_y); mul_b = MUL_W'(sum_mov_x); end
      OP_SRX_SMY: begin mul_a = MUL_W'(sum_ref_x); mul_b = MUL_W'(sum_mov_y); end
      OP_NDT_LO:  begin
        mul_a = $signed(MUL_W'(pair_count));
        mul_b = $signed(MUL_W'(sum_dot[SPLIT-1:0]));
      end
      OP_NDT_HI:  begin
        mul_a = $signed(MUL_W'(pair_count));
        mul_b = MUL_W'(sum_dot >>> SPLIT);
      end
      OP_SRX_SMX: begin mul_a = MUL_W'(sum_ref_x); mul_b = MUL_W'(sum_mov_x); end
      OP_SRY_SMY: begin mul_a = MUL_W'(sum_ref_y); mul_b = MUL_W'(sum_mov_y); end
      OP_C_SMX:   begin mul_a = MUL_W'(cos_r); mul_b = MUL_W'(sum_mov_x); end
      OP_S_SMY:   begin mul_a = MUL_W'(sin_r); mul_b = MUL_W'(sum_mov_y); end
      OP_S_SMX:   begin mul_a = MUL_W'(sin_r); mul_b = MUL_W'(sum_mov_x); end
      OP_C_SMY:   begin mul_a = MUL_W'(cos_r); mul_b = MUL_W'(sum_mov_y); end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // CORDIC and divider requests
  always_comb begin
    ax = ACC_W'(vx[ACC_W-1] ? -vx : vx);
    ay = ACC_W'(vy[ACC_W-1] ? -vy : vy);

    // Angle: clamp to +-pi, round Q.29 to Q3.13 half away from zero
    if (cord_z > PI_Q29) begin
      zc = PI_Q29;
    end else if (cord_z < -PI_Q29) begin
      zc = -PI_Q29;
    end else begin
      zc = cord_z;
    end
    az       = zc[CW-1] ? -zc : zc;
    aq       = ANG_W'((az + ANG_ROUND) >>> ANG_SHIFT);
    ang_next = zc[CW-1] ? -aq : aq;

    // Fold the emitted angle into [-pi/2, pi/2]
    th = CW'(angle_r) <<< ANG_SHIFT;
    if (th > HALF_PI_Q29) begin
      th_fold  = th - PI_Q29;
      fold_neg = 1'b1;
    end else if (th < -HALF_PI_Q29) begin
      th_fold  = th + PI_Q29;
      fold_neg = 1'b1;
    end else begin
      th_fold  = th;
      fold_neg = 1'b0;
    end

    cord_req.start  = (state == VEC_GO) || (state == ROT_GO);
    cord_req.rotate = (state == ROT_GO);
    cord_x0 = cord_req.rotate ? UNIT_Q30 : CW'(vx);
    cord_y0 = cord_req.rotate ? '0 : CW'(vy);
    cord_z0 = cord_req.rotate ? th_fold : zinit;

    div_start = (state == COS_GO) || (state == SIN_GO) ||
                (state == SHX_GO) || (state == SHY_GO);
    unique case (state)
      COS_GO:  begin div_n = ACC_W'(cx) <<< FRAC_Q15; div_d = KQ; end
      SIN_GO:  begin div_n = ACC_W'(cy) <<< FRAC_Q15; div_d = KQ; end
      SHX_GO:  begin div_n = num; div_d = DVSR_W'(pair_count) << FRAC_Q15; end
      SHY_GO:  begin div_n = den; div_d = DVSR_W'(pair_count) << FRAC_Q15; end
      default: begin div_n = num; div_d = KQ; end
    endcase

    if (quo > TRIG_HI) begin
      trig_sat = TRIG_W'(TRIG_HI);
    end else if (quo < TRIG_LO) begin
      trig_sat = TRIG_W'(TRIG_LO);
    end else begin
      trig_sat = TRIG_W'(quo);
    end
    if (quo > SHIFT_HI) begin
      shift_sat = SHIFT_W'(SHIFT_HI);
    end else if (quo < SHIFT_LO) begin
      shift_sat = SHIFT_W'(SHIFT_LO);
    end else begin
      shift_sat = SHIFT_W'(quo);
    end
  end

  rpm_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .en   (mul_en),
    .op   (op_cur),
    .a    (mul_a),
    .b    (mul_b),
    .vld  (mul_vld),
    .tag  (mul_tag),
    .prod (prod)
  );

  rpm_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (cord_req),
    .x0   (cord_x0),
    .y0   (cord_y0),
    .z0   (cord_z0),
    .done (cord_done),
    .x    (cord_x),
    .y    (cord_y),
    .z    (cord_z)
  );

  rpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      sum_ref_x  <= '0;
      sum_ref_y  <= '0;
      sum_mov_x  <= '0;
      sum_mov_y  <= '0;
      sum_dot    <= '0;
      sum_cross  <= '0;
      pair_count <= '0;
      op_cur     <= OP_RX_MX;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Fold the registered product into its target
      if (mul_vld) begin
        unique case (mul_tag)
          OP_RX_MX, OP_RY_MY: sum_dot   <= sum_dot + XSUM_W'(prod);
          OP_RY_MX:           sum_cross <= sum_cross + XSUM_W'(prod);
          OP_RX_MY:           sum_cross <= sum_cross - XSUM_W'(prod);
          OP_NCR_LO:          num <= num + prod;
          OP_NCR_HI:          num <= num + (prod <<< SPLIT);
          OP_SRY_SMX:         num <= num - prod;
          OP_SRX_SMY:         num <= num + prod;
          OP_NDT_LO:          den <= den + prod;
          OP_NDT_HI:          den <= den + (prod <<< SPLIT);
          OP_SRX_SMX:         den <= den - prod;
          OP_SRY_SMY:         den <= den - prod;
          OP_C_SMX:           num <= num - prod;
          OP_S_SMY:           num <= num + prod;
          OP_S_SMX:           den <= den - prod;
          OP_C_SMY:           den <= den - prod;
          default:            ;
        endcase
      end

      unique case (state)
        IDLE: begin
          if (take_in) begin
            rx     <= ref_x;
            ry     <= ref_y;
            mx     <= mov_x;
            my     <= mov_y;
            last_r <= last_point;
            if (pair_count < CNT_W'(MAX_PAIRS)) begin
              sum_ref_x  <= sum_ref_x + SUM_W'(ref_x);
              sum_ref_y  <= sum_ref_y + SUM_W'(ref_y);
              sum_mov_x  <= sum_mov_x + SUM_W'(mov_x);
              sum_mov_y  <= sum_mov_y + SUM_W'(mov_y);
              pair_count <= pair_count + 1'b1;
              op_cur     <= OP_RX_MX;
              state      <= PT_MUL;
            end else if (last_point) begin
              // pair past the limit is dropped, the set is still solved
              num    <= '0;
              den    <= '0;
              op_cur <= OP_NCR_LO;
              state  <= FIN_MUL;
            end
          end
        end
        PT_MUL: begin
          if (op_cur == OP_RX_MY) begin
            state <= PT_DRAIN;
          end else begin
            op_cur <= op_t'(op_cur + 4'd1);
          end
        end
        PT_DRAIN: begin
          if (last_r) begin
            num    <= '0;
            den    <= '0;
            op_cur <= OP_NCR_LO;
            state  <= FIN_MUL;
          end else begin
            state <= IDLE;
          end
        end
        FIN_MUL: begin
          if (op_cur == OP_SRY_SMY) begin
            state <= FIN_DRAIN;
          end else begin
            op_cur <= op_t'(op_cur + 4'd1);
          end
        end
        FIN_DRAIN: state <= PREP;
        PREP: begin
          if (num == '0 && den == '0) begin
            // degenerate set: identity rotation
            angle_r <= '0;
            cos_r   <= COS_ONE;
            sin_r   <= '0;
            num     <= ACC_W'(sum_ref_x) <<< FRAC_Q15;
            den     <= ACC_W'(sum_ref_y) <<< FRAC_Q15;
            op_cur  <= OP_C_SMX;
            state   <= SH_MUL;
          end else begin
            if (den[ACC_W-1]) begin
              vx    <= -den;
              vy    <= -num;
              zinit <= num[ACC_W-1] ? -PI_Q29 : PI_Q29;
            end else begin
              vx    <= den;
              vy    <= num;
              zinit <= '0;
            end
            state <= MAG;
          end
        end
        MAG: begin
          m     <= (ax > ay) ? ax : ay;
          state <= NORM;
        end
        NORM: begin
          // one bit a cycle until the larger magnitude sits in [2^28, 2^29)
          if (m >= NORM_HI) begin
            vx <= vx >>> 1;
            vy <= vy >>> 1;
            m  <= m >> 1;
          end else if (m < NORM_LO) begin
            vx <= vx <<< 1;
            vy <= vy <<< 1;
            m  <= m << 1;
          end else begin
            state <= VEC_GO;
          end
        end
        VEC_GO: state <= VEC_WAIT;
        VEC_WAIT: begin
          if (cord_done) begin
            angle_r <= ang_next;
            state   <= ROT_GO;
          end
        end
        ROT_GO: begin
          rot_neg <= fold_neg;
          state   <= ROT_WAIT;
        end
        ROT_WAIT: begin
          if (cord_done) begin
            cx    <= rot_neg ? -cord_x : cord_x;
            cy    <= rot_neg ? -cord_y : cord_y;
            state <= COS_GO;
          end
        end
        COS_GO: state <= COS_WAIT;
        COS_WAIT: begin
          if (div_done) begin
            cos_r <= trig_sat;
            state <= SIN_GO;
          end
        end
        SIN_GO: state <= SIN_WAIT;
        SIN_WAIT: begin
          if (div_done) begin
            sin_r  <= trig_sat;
            num    <= ACC_W'(sum_ref_x) <<< FRAC_Q15;
            den    <= ACC_W'(sum_ref_y) <<< FRAC_Q15;
            op_cur <= OP_C_SMX;
            state  <= SH_MUL;
          end
        end
        SH_MUL: begin
          if (op_cur == OP_C_SMY) begin
            state <= SH_DRAIN;
          end else begin
            op_cur <= op_t'(op_cur + 4'd1);
          end
        end
        SH_DRAIN: state <= SHX_GO;
        SHX_GO:   state <= SHX_WAIT;
        SHX_WAIT: begin
          if (div_done) begin
            shx_r <= shift_sat;
            state <= SHY_GO;
          end
        end
        SHY_GO: state <= SHY_WAIT;
        SHY_WAIT: begin
          if (div_done) begin
            shy_r <= shift_sat;
            state <= EMIT;
          end
        end
        EMIT: begin
          if (emit_go) begin
            angle_theta <= angle_r;
            cos_theta   <= cos_r;
            sin_theta   <= sin_r;
            shift_x     <= shx_r;
            shift_y     <= shy_r;
            out_valid   <= 1'b1;
            sum_ref_x   <= '0;
            sum_ref_y   <= '0;
            sum_mov_x   <= '0;
            sum_mov_y   <= '0;
            sum_dot     <= '0;
            sum_cross   <= '0;
            pair_count  <= '0;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Checks

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    pair_count <= CNT_W'(MAX_PAIRS))
    else $error("pair count above limit");

  a_prod_consumed: assert property (@(posedge clk) disable iff (rst)
    mul_vld |-> (state == PT_MUL || state == PT_DRAIN || state == FIN_MUL ||
                 state == FIN_DRAIN || state == SH_MUL || state == SH_DRAIN))
    else $error("product arrived outside a multiply phase");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    state == VEC_GO |-> (m >= NORM_LO && m < NORM_HI))
    else $error("CORDIC started on unnormalized vector");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (out_valid && pair_count == '0 && state == IDLE))
    else $error("result emit did not clear the set");

endmodule

`default_nettype wire
